@@ hw/rtl/gbba_pkg.sv @@
// Shared constants, codes, types and helpers of the grouped bitmap block allocator.
`timescale 1ns / 1ps

package gbba_pkg;

  localparam int MAX_GROUPS = 16;
  localparam int SLOT_BITS  = 32768;
  localparam int GROUP_W    = 4;
  localparam int WORD_W     = 10;
  localparam int ADDR_W     = GROUP_W + WORD_W;
  localparam int MEM_DEPTH  = MAX_GROUPS * (SLOT_BITS / 32);
  localparam int BLK_W      = 19;
  localparam int CNT_W      = 20;
  localparam int BPG_W      = 16;
  localparam int GC_W       = 5;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_MARK  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_ALREADY  = 2'd3;

  localparam logic REG_GROUP_COUNT      = 1'b0;
  localparam logic REG_BLOCKS_PER_GROUP = 1'b1;

  localparam logic [GC_W-1:0]  GC_RESET  = 5'd1;
  localparam logic [BPG_W-1:0] BPG_RESET = 16'd32768;
  localparam logic [BPG_W-1:0] BPG_MIN   = 16'd8;
  localparam logic [BPG_W-1:0] BPG_MAX   = 16'(SLOT_BITS);
  localparam logic [GC_W-1:0]  GC_MAX    = 5'(MAX_GROUPS);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RMW_RD,
    ST_RMW_CHK,
    ST_AL_GRP,
    ST_AL_NEXT,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_SUM,
    ST_TOT_DIFF,
    ST_TOT_ADD
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Position of the lowest clear bit; only meaningful when one exists.
  function automatic logic [4:0] lowest_clear(input logic [31:0] word);
    logic [4:0] pos;
    pos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

@@ hw/rtl/gbba_alu.sv @@
// Shared add/subtract unit for the sequencer's arithmetic; index and address counters step outside it.
`timescale 1ns / 1ps

module gbba_alu
  import gbba_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [CNT_W:0] sum;

  // Subtract as a plus inverted b plus one; carry high means a >= b.
  assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{CNT_W{1'b0}}, req.sub};

  assign rsp.res   = sum[CNT_W-1:0];
  assign rsp.carry = sum[CNT_W];

endmodule

@@ hw/rtl/gbba_bitmap_mem.sv @@
// Usage bitmap storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module gbba_bitmap_mem
  import gbba_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

@@ hw/rtl/grouped_bitmap_block_allocator_unit.sv @@
// Top level: sequencer, configuration, used counts and result register.
//
// Block allocator over a per-group usage bitmap of 32-bit words (16 groups of 1024 words).
// After reset a clearing pass zeroes the bitmap, one word per cycle; no item is taken during
// it. Every item then runs alone through a sequencer that drives one shared 20-bit adder.
// Allocate skips each group that is full on its used count and searches the others one
// bitmap word per cycle from the single read port; when nothing is free the scan ends.
// Free and mark split the block number by repeated subtraction, one group tried at a time
// (at most group_count), then do a read-modify-write of the word. Every item ends by
// rebuilding total_free, a difference and an add per group in use, then loads the result
// register.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator_unit
  import gbba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [BPG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        mode,
  input  logic [BLK_W-1:0]  block_number,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BLK_W-1:0]  allocated_block,
  output logic [1:0]        status,
  output logic [CNT_W-1:0]  total_free
);

  state_t state, state_next;

  logic [GC_W-1:0]    group_count;
  logic [BPG_W-1:0]   blocks_per_group;
  logic [GC_W-1:0]    gc_eff;
  logic [BPG_W-1:0]   bpg_eff;
  logic [BPG_W-1:0]   bpg_m1;
  logic [WORD_W-1:0]  last_w;
  logic [31:0]        hi_mask;

  logic [15:0]        used [MAX_GROUPS];
  logic               used_we;

  logic [1:0]         op_mode, op_mode_next;
  logic [CNT_W-1:0]   rem, rem_next;
  logic [GC_W-1:0]    g_cnt, g_cnt_next;
  logic [WORD_W-1:0]  w_idx, w_idx_next;
  logic [CNT_W-1:0]   base, base_next;
  logic [14:0]        idx, idx_next;
  logic [BPG_W-1:0]   diff, diff_next;
  logic [CNT_W-1:0]   acc, acc_next;
  logic [1:0]         res_status, res_status_next;
  logic [BLK_W-1:0]   res_blk, res_blk_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic               out_valid_next;
  logic [BLK_W-1:0]   allocated_block_next;
  logic [1:0]         status_next;
  logic [CNT_W-1:0]   total_free_next;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  mem_req_t           mem_req;
  logic [31:0]        rd_data;
  logic [31:0]        masked;
  logic [4:0]         hit_bit;
  logic               bit_set;
  logic [15:0]        used_cur;

  gbba_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gbba_bitmap_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count      <= GC_RESET;
      blocks_per_group <= BPG_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_GROUP_COUNT) begin
        group_count <= cfg_data[GC_W-1:0];
      end else begin
        blocks_per_group <= cfg_data;
      end
    end
  end

  assign gc_eff  = (group_count > GC_MAX) ? GC_MAX : group_count;
  assign bpg_eff = (blocks_per_group < BPG_MIN) ? BPG_MIN :
                   (blocks_per_group > BPG_MAX) ? BPG_MAX : blocks_per_group;
  assign bpg_m1  = bpg_eff - 16'd1;
  assign last_w  = bpg_m1[14:5];
  // Bits of the last word at or above blocks_per_group read as used.
  assign hi_mask = ~(32'hFFFF_FFFF >> (5'd31 - bpg_m1[4:0]));

  assign used_cur = used[g_cnt[GROUP_W-1:0]];
  assign masked   = rd_data | ((w_idx == last_w) ? hi_mask : 32'd0);
  assign hit_bit  = lowest_clear(masked);
  assign bit_set  = rd_data[rem[4:0]];
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next           = state;
    op_mode_next         = op_mode;
    rem_next             = rem;
    g_cnt_next           = g_cnt;
    w_idx_next           = w_idx;
    base_next            = base;
    idx_next             = idx;
    diff_next            = diff;
    acc_next             = acc;
    res_status_next      = res_status;
    res_blk_next         = res_blk;
    clr_addr_next        = clr_addr;
    out_valid_next       = out_valid && out_stall;
    allocated_block_next = allocated_block;
    status_next          = status;
    total_free_next      = total_free;
    used_we              = 1'b0;
    alu_req              = '0;
    mem_req.we           = 1'b0;
    mem_req.waddr        = {g_cnt[GROUP_W-1:0], w_idx};
    mem_req.wdata        = '0;
    mem_req.raddr        = {g_cnt[GROUP_W-1:0], w_idx};

    unique case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_mode_next    = mode;
          rem_next        = {1'b0, block_number};
          g_cnt_next      = '0;
          w_idx_next      = '0;
          base_next       = '0;
          acc_next        = '0;
          res_status_next = STAT_OK;
          res_blk_next    = '0;
          unique case (mode)
            MODE_ALLOC: state_next = ST_AL_GRP;
            MODE_FREE,
            MODE_MARK:  state_next = ST_DIV;
            default:    state_next = ST_TOT_DIFF;
          endcase
        end
      end

      ST_DIV: begin
        alu_req.a   = rem;
        alu_req.b   = {4'd0, bpg_eff};
        alu_req.sub = 1'b1;
        if (gc_eff == '0) begin
          res_status_next = STAT_RANGE;
          state_next      = ST_TOT_DIFF;
        end else if (!alu_rsp.carry) begin
          state_next = ST_RMW_RD;
        end else if (g_cnt + 5'd1 == gc_eff) begin
          res_status_next = STAT_RANGE;
          g_cnt_next      = '0;
          state_next      = ST_TOT_DIFF;
        end else begin
          rem_next   = alu_rsp.res;
          g_cnt_next = g_cnt + 5'd1;
        end
      end

      ST_RMW_RD: begin
        mem_req.raddr = {g_cnt[GROUP_W-1:0], rem[14:5]};
        state_next    = ST_RMW_CHK;
      end

      ST_RMW_CHK: begin
        mem_req.waddr = {g_cnt[GROUP_W-1:0], rem[14:5]};
        alu_req.a     = {4'd0, used_cur};
        alu_req.b     = 20'd1;
        alu_req.sub   = (op_mode == MODE_FREE);
        if (op_mode == MODE_FREE) begin
          if (!bit_set) begin
            res_status_next = STAT_ALREADY;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = rd_data & ~(32'd1 << rem[4:0]);
            used_we       = 1'b1;
          end
        end else begin
          if (bit_set) begin
            res_status_next = STAT_ALREADY;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.wdata = rd_data | (32'd1 << rem[4:0]);
            used_we       = 1'b1;
          end
        end
        g_cnt_next = '0;
        state_next = ST_TOT_DIFF;
      end

      ST_AL_GRP: begin
        alu_req.a   = {4'd0, used_cur};
        alu_req.b   = {4'd0, bpg_eff};
        alu_req.sub = 1'b1;
        if (g_cnt == gc_eff) begin
          res_status_next = STAT_NO_SPACE;
          g_cnt_next      = '0;
          state_next      = ST_TOT_DIFF;
        end else if (alu_rsp.carry) begin
          // group full on its count: skip
          state_next = ST_AL_NEXT;
        end else begin
          w_idx_next = '0;
          state_next = ST_AL_RD;
        end
      end

      ST_AL_NEXT: begin
        alu_req.a  = base;
        alu_req.b  = {4'd0, bpg_eff};
        base_next  = alu_rsp.res;
        g_cnt_next = g_cnt + 5'd1;
        state_next = ST_AL_GRP;
      end

      ST_AL_RD: begin
        state_next = ST_AL_CHK;
      end

      ST_AL_CHK: begin
        alu_req.a = {4'd0, used_cur};
        alu_req.b = 20'd1;
        if (&masked) begin
          if (w_idx == last_w) begin
            state_next = ST_AL_NEXT;
          end else begin
            // advance and fetch the next word in the same cycle
            w_idx_next    = w_idx + 1'b1;
            mem_req.raddr = {g_cnt[GROUP_W-1:0], w_idx + 1'b1};
          end
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rd_data | (32'd1 << hit_bit);
          used_we       = 1'b1;
          idx_next      = {w_idx, hit_bit};
          state_next    = ST_AL_SUM;
        end
      end

      ST_AL_SUM: begin
        alu_req.a    = base;
        alu_req.b    = {5'd0, idx};
        res_blk_next = alu_rsp.res[BLK_W-1:0];
        g_cnt_next   = '0;
        state_next   = ST_TOT_DIFF;
      end

      ST_TOT_DIFF: begin
        alu_req.a   = {4'd0, bpg_eff};
        alu_req.b   = {4'd0, used_cur};
        alu_req.sub = 1'b1;
        if (g_cnt == gc_eff) begin
          // hold until the result register is free
          if (!(out_valid && out_stall)) begin
            out_valid_next       = 1'b1;
            allocated_block_next = res_blk;
            status_next          = res_status;
            total_free_next      = acc;
            state_next           = ST_IDLE;
          end
        end else begin
          diff_next  = alu_rsp.carry ? alu_rsp.res[BPG_W-1:0] : '0;
          state_next = ST_TOT_ADD;
        end
      end

      ST_TOT_ADD: begin
        alu_req.a  = acc;
        alu_req.b  = {4'd0, diff};
        acc_next   = alu_rsp.res;
        g_cnt_next = g_cnt + 5'd1;
        state_next = ST_TOT_DIFF;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        used[i] <= '0;
      end
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
      if (used_we) begin
        used[g_cnt[GROUP_W-1:0]] <= alu_rsp.res[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_mode         <= op_mode_next;
    rem             <= rem_next;
    g_cnt           <= g_cnt_next;
    w_idx           <= w_idx_next;
    base            <= base_next;
    idx             <= idx_next;
    diff            <= diff_next;
    acc             <= acc_next;
    res_status      <= res_status_next;
    res_blk         <= res_blk_next;
    allocated_block <= allocated_block_next;
    status          <= status_next;
    total_free      <= total_free_next;
  end

  a_no_space_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_NO_SPACE) |-> (allocated_block == '0))
    else $error("no-space result carries a block number");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_free <= 20'd524288))
    else $error("total_free above the bitmap size");

  a_hit_group: assert property (@(posedge clk) disable iff (rst)
    (state == ST_AL_CHK) |-> ({1'b0, g_cnt} < {1'b0, gc_eff}))
    else $error("bitmap scan in a group not in use");

  a_local_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW_CHK) |-> (rem < {4'd0, bpg_eff}))
    else $error("block index within group not below blocks_per_group");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && mem_req.we))
    else $error("clearing pass interrupted");

endmodule
